FILE: rtl/core/music_sequence_event_parser_defines.svh
// Assertion macros shared by the RTL.
`ifndef MUSIC_SEQUENCE_EVENT_PARSER_DEFINES_SVH
`define MUSIC_SEQUENCE_EVENT_PARSER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset.
`define MSEP_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msep check failed");

// Next-cycle implication, checked out of reset.
`define MSEP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msep check failed");

`else

`define MSEP_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define MSEP_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/msep_pkg.sv
`default_nettype none

package msep_pkg;

  localparam int DELAY_BITS_DEF = 28;
  localparam int DELAY_W        = 28;
  localparam int ADDR_W         = 20;
  localparam int CFG_W          = 20;

  // input word commands
  localparam logic [1:0] CMD_DATA = 2'd0;
  localparam logic [1:0] CMD_END  = 2'd1;
  localparam logic [1:0] CMD_NEW  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_CHAN   = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_REWIND = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_VERSION    = 2'd0;
  localparam logic [1:0] REG_LOOP_LIMIT = 2'd1;
  localparam logic [1:0] REG_SONG_START = 2'd2;

  // stream byte values
  localparam logic [7:0] BYTE_DELAY_CHAIN = 8'hF8;
  localparam logic [7:0] BYTE_LOOP_CMD    = 8'hFC;
  localparam logic [7:0] BYTE_LOOP_ARG    = 8'h80;
  localparam logic [7:0] BYTE_CTRL        = 8'hB0;
  localparam logic [7:0] BYTE_CC_LOOP     = 8'h6F;
  localparam logic [7:0] BYTE_CC_UNKNOWN  = 8'h6E;
  localparam logic [7:0] BYTE_VEL_OFF     = 8'h40;
  localparam logic [7:0] BYTE_VEL_ON      = 8'h7F;
  localparam logic [7:0] BYTE_META_EOT    = 8'h2F;
  localparam logic [7:0] BYTE_META        = 8'hFF;

  typedef struct packed {
    logic [1:0]         kind;
    logic [DELAY_W-1:0] delay;
    logic [7:0]         status;
    logic [7:0]         data1;
    logic [7:0]         data2;
    logic [ADDR_W-1:0]  rewind_address;
    logic               last;
  } result_t;

  typedef struct packed {
    logic vld;   // one or two results go into the queue
    logic two;   // two results
  } push_t;

  function automatic result_t mk_result(input logic [1:0] kind,
                                        input logic [DELAY_W-1:0] delay,
                                        input logic [7:0] status,
                                        input logic [7:0] data1,
                                        input logic [7:0] data2,
                                        input logic [ADDR_W-1:0] addr);
    result_t r;
    r.kind           = kind;
    r.delay          = delay;
    r.status         = status;
    r.data1          = data1;
    r.data2          = data2;
    r.rewind_address = addr;
    r.last           = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/msep_parser.sv
`default_nettype none

module msep_parser #(
  parameter int DELAY_BITS = msep_pkg::DELAY_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [msep_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                        acc_i,
  input  wire logic [1:0]                  command_i,
  input  wire logic [7:0]                  data_byte_i,
  output msep_pkg::push_t                  push_o,
  output msep_pkg::result_t                res0_o,
  output msep_pkg::result_t                res1_o
);
  import msep_pkg::*;

  localparam logic [2:0] PH_DELAY = 3'd0;
  localparam logic [2:0] PH_CMD   = 3'd1;
  localparam logic [2:0] PH_OP1   = 3'd2;
  localparam logic [2:0] PH_OP2   = 3'd3;

  localparam logic [DELAY_BITS-1:0] DELAY_MAX = {DELAY_BITS{1'b1}};

  // configuration
  logic [1:0]        version_r;
  logic [15:0]       loop_limit_r;
  logic [ADDR_W-1:0] song_start_r;

  // parse state
  logic [2:0]            phase_r, phase_nxt;
  logic [DELAY_BITS-1:0] acc_r, acc_nxt;
  logic [7:0]            rc_r, rc_nxt;
  logic [7:0]            fo_r, fo_nxt;
  logic [15:0]           lc_r, lc_nxt;
  logic                  ended_r, ended_nxt;

  logic [DELAY_BITS:0]   sum;
  logic [DELAY_W-1:0]    acc_out;
  logic [15:0]           lc_inc;
  logic                  do_unknown;
  logic                  do_first;
  logic [7:0]            unk_cmd;
  logic [3:0]            hi_nib;
  result_t               r0, r1;
  push_t                 push;

  function automatic logic cmd_known(input logic [7:0] c);
    return (c[7:4] inside {4'h8, 4'h9, 4'hB, 4'hC, 4'hE}) || (c == BYTE_LOOP_CMD);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r    <= 2'd1;
      loop_limit_r <= 16'd2;
      song_start_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_VERSION:    version_r    <= cfg_data[1:0];
        REG_LOOP_LIMIT: loop_limit_r <= cfg_data[15:0];
        REG_SONG_START: song_start_r <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign sum     = {1'b0, acc_r} + (DELAY_BITS+1)'(data_byte_i);
  assign acc_out = DELAY_W'(acc_r);
  assign lc_inc  = lc_r + 16'd1;
  assign hi_nib  = rc_r[7:4];

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    rc_nxt     = rc_r;
    fo_nxt     = fo_r;
    lc_nxt     = lc_r;
    ended_nxt  = ended_r;
    do_unknown = 1'b0;
    do_first   = 1'b0;
    unk_cmd    = rc_r;
    r0         = '0;
    r1         = '0;
    push       = '0;

    if (acc_i) begin
      if (command_i == CMD_NEW) begin
        phase_nxt = PH_DELAY;
        acc_nxt   = '0;
        rc_nxt    = '0;
        fo_nxt    = '0;
        lc_nxt    = '0;
        ended_nxt = 1'b0;
      end else if ((command_i == CMD_END) && !ended_r) begin
        r0        = mk_result(KIND_END, acc_out, BYTE_META, BYTE_META_EOT, 8'h00, '0);
        push.vld  = 1'b1;
        ended_nxt = 1'b1;
        phase_nxt = PH_DELAY;
        acc_nxt   = '0;
      end else if ((command_i == CMD_DATA) && !ended_r) begin
        case (phase_r)
          PH_DELAY: begin
            acc_nxt = sum[DELAY_BITS] ? DELAY_MAX : sum[DELAY_BITS-1:0];
            if (data_byte_i != BYTE_DELAY_CHAIN) begin
              phase_nxt = PH_CMD;
            end
          end
          PH_CMD: begin
            if (data_byte_i[7]) begin
              rc_nxt = data_byte_i;
              if (!cmd_known(data_byte_i)) begin
                do_unknown = 1'b1;
                unk_cmd    = data_byte_i;
              end else begin
                phase_nxt = PH_OP1;
              end
            end else if (!cmd_known(rc_r)) begin
              do_unknown = 1'b1;
            end else begin
              do_first = 1'b1;
            end
          end
          PH_OP1: do_first = 1'b1;
          PH_OP2: begin
            phase_nxt = PH_DELAY;
            r0        = mk_result(KIND_CHAN, acc_out, rc_r, fo_r, data_byte_i, '0);
            push.vld  = 1'b1;
            acc_nxt   = '0;
          end
          default: phase_nxt = PH_DELAY;
        endcase
      end
    end

    // unknown command: controller 6E, then end of track
    if (do_unknown) begin
      r0        = mk_result(KIND_CHAN, acc_out, BYTE_CTRL, BYTE_CC_UNKNOWN,
                            {1'b0, unk_cmd[6:0]}, '0);
      r1        = mk_result(KIND_END, '0, BYTE_META, BYTE_META_EOT, 8'h00, '0);
      push      = '{vld: 1'b1, two: 1'b1};
      ended_nxt = 1'b1;
      phase_nxt = PH_DELAY;
      acc_nxt   = '0;
    end

    // first operand of the running command
    if (do_first) begin
      if (rc_r == BYTE_LOOP_CMD) begin
        phase_nxt = PH_DELAY;
        push.vld  = 1'b1;
        if (data_byte_i != BYTE_LOOP_ARG) begin
          r0        = mk_result(KIND_END, acc_out, BYTE_META, BYTE_META_EOT, 8'h00, '0);
          ended_nxt = 1'b1;
          acc_nxt   = '0;
        end else begin
          lc_nxt = lc_inc;
          if (lc_inc[15:7] == '0) begin
            // loop marker, then rewind or end
            r0       = mk_result(KIND_CHAN, acc_out, BYTE_CTRL, BYTE_CC_LOOP,
                                 lc_inc[7:0], '0);
            push.two = 1'b1;
            acc_nxt  = '0;
            if (lc_inc < loop_limit_r) begin
              r1 = mk_result(KIND_REWIND, '0, 8'h00, 8'h00, 8'h00, song_start_r);
            end else begin
              r1        = mk_result(KIND_END, '0, BYTE_META, BYTE_META_EOT, 8'h00, '0);
              ended_nxt = 1'b1;
            end
          end else if (lc_inc < loop_limit_r) begin
            // rewind alone keeps the accumulated delay
            r0 = mk_result(KIND_REWIND, '0, 8'h00, 8'h00, 8'h00, song_start_r);
          end else begin
            r0        = mk_result(KIND_END, acc_out, BYTE_META, BYTE_META_EOT, 8'h00, '0);
            ended_nxt = 1'b1;
            acc_nxt   = '0;
          end
        end
      end else if ((hi_nib == 4'h8 || hi_nib == 4'h9) && version_r == 2'd2) begin
        phase_nxt = PH_DELAY;
        r0        = mk_result(KIND_CHAN, acc_out, rc_r, data_byte_i,
                              (hi_nib == 4'h8) ? BYTE_VEL_OFF : BYTE_VEL_ON, '0);
        push.vld  = 1'b1;
        acc_nxt   = '0;
      end else if (hi_nib == 4'hC) begin
        phase_nxt = PH_DELAY;
        r0        = mk_result(KIND_CHAN, acc_out, rc_r, data_byte_i, 8'h00, '0);
        push.vld  = 1'b1;
        acc_nxt   = '0;
      end else begin
        fo_nxt    = data_byte_i;
        phase_nxt = PH_OP2;
      end
    end

    r0.last = !push.two;
    r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELAY;
      acc_r   <= '0;
      rc_r    <= '0;
      fo_r    <= '0;
      lc_r    <= '0;
      ended_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      rc_r    <= rc_nxt;
      fo_r    <= fo_nxt;
      lc_r    <= lc_nxt;
      ended_r <= ended_nxt;
    end
  end

  assign push_o = push;
  assign res0_o = r0;
  assign res1_o = r1;

endmodule

`default_nettype wire

FILE: rtl/core/msep_outq.sv
`default_nettype none

module msep_outq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire msep_pkg::push_t   push_i,
  input  wire msep_pkg::result_t res0_i,
  input  wire msep_pkg::result_t res1_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output msep_pkg::result_t      out_o
);
  import msep_pkg::*;

  // two slots, each holding the one or two results of one input word
  result_t    r0_q [2];
  result_t    r1_q [2];
  logic [1:0] two_q;

  logic       wr_ptr_r, rd_ptr_r, sub_r;
  logic [1:0] cnt_r;
  logic       pop, pop_slot;

  assign out_valid_o = (cnt_r != 2'd0);
  assign full_o      = (cnt_r == 2'd2);
  assign out_o       = sub_r ? r1_q[rd_ptr_r] : r0_q[rd_ptr_r];
  assign pop         = out_valid_o && !out_stall_i;
  assign pop_slot    = pop && (sub_r || !two_q[rd_ptr_r]);

  always_ff @(posedge clk) begin
    if (push_i.vld) begin
      r0_q[wr_ptr_r]  <= res0_i;
      r1_q[wr_ptr_r]  <= res1_i;
      two_q[wr_ptr_r] <= push_i.two;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      sub_r    <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_i.vld) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop_slot) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (pop) begin
        sub_r <= !pop_slot;
      end
      cnt_r <= cnt_r + {1'b0, push_i.vld} - {1'b0, pop_slot};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/music_sequence_event_parser.sv
`default_nettype none
// Channel   Direction  Handshake          Word
// in_       sink       in_valid/in_stall  command, data_byte
// out_      source     out_valid/out_stall kind, delay, status, data1, data2,
//                                          rewind_address, last
// cfg_      sink       cfg_wr_en          cfg_index, cfg_data
//
// One input word per cycle while in_stall is low; accepted results are registered in the result queue.
// A word yields zero, one or two results; a pair leaves as two separate output words.
// Reset: synchronous, active-low rst_n; clears parse state, config regs go to defaults.
// in_stall rises when the two-slot result queue is full: a held output, or a
// result pair followed at once by more results.

`include "music_sequence_event_parser_defines.svh"

module music_sequence_event_parser #(
  parameter int DELAY_BITS = msep_pkg::DELAY_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // configuration
  input  wire logic                        cfg_wr_en,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [msep_pkg::CFG_W-1:0]  cfg_data,
  // input stream
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_command,
  input  wire logic [7:0]                  in_data_byte,
  // result stream
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_kind,
  output logic [msep_pkg::DELAY_W-1:0]     out_delay,
  output logic [7:0]                       out_status,
  output logic [7:0]                       out_data1,
  output logic [7:0]                       out_data2,
  output logic [msep_pkg::ADDR_W-1:0]      out_rewind_address,
  output logic                             out_last
);
  import msep_pkg::*;

  logic    in_acc;
  push_t   push;
  result_t res0, res1, head;
  logic    q_full;

  assign in_stall = q_full;
  assign in_acc   = in_valid && !q_full;

  // parse state, config registers and result formation
  msep_parser #(
    .DELAY_BITS (DELAY_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .acc_i       (in_acc),
    .command_i   (in_command),
    .data_byte_i (in_data_byte),
    .push_o      (push),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  // result queue; splits a result pair into two output words
  msep_outq u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .res0_i      (res0),
    .res1_i      (res1),
    .full_o      (q_full),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (head)
  );

  assign out_kind           = head.kind;
  assign out_delay          = head.delay;
  assign out_status         = head.status;
  assign out_data1          = head.data1;
  assign out_data2          = head.data2;
  assign out_rewind_address = head.rewind_address;
  assign out_last           = head.last;

  // first word of a pair is always a controller event
  `MSEP_ASSERT_NOW(a_pair_head_chan, clk, rst_n, out_valid && !out_last, out_kind == KIND_CHAN)
  // end of track always closes the words of its input
  `MSEP_ASSERT_NOW(a_end_is_last, clk, rst_n, out_valid && out_kind == KIND_END, out_last)
  // rewind requests carry no delay
  `MSEP_ASSERT_NOW(a_rewind_nodelay, clk, rst_n, out_valid && out_kind == KIND_REWIND, out_delay == '0)
  // second word of a pair is waiting right after the first leaves
  `MSEP_ASSERT_NEXT(a_pair_tail, clk, rst_n, out_valid && !out_stall && !out_last, out_valid)

endmodule

`default_nettype wire
